// ----- hdl/sdsr_pkg.sv -----
// sdsr_pkg: shared constants, types and lookup functions of the signed decimal
// seven-segment renderer; no dependencies
`default_nettype none

package sdsr_pkg;

   // field widths
   localparam int MAG_W        = 64;
   localparam int ADDR_W       = 7;
   localparam int SEG_W        = 7;

   // binary to bcd conversion: 65 bits shifted in, 5 per cycle
   localparam int BCD_DIGITS   = 20;
   localparam int STEP_BITS    = 5;
   localparam int CONV_STEPS   = 13;
   localparam int BIN_W        = STEP_BITS * CONV_STEPS;
   localparam int STEP_CNT_W   = $clog2(CONV_STEPS + 1);

   // display geometry
   localparam int DIGIT_COUNT_DEFAULT = 13;
   localparam int PHYS_COLUMNS        = 13;

   // clamp limits
   localparam logic [MAG_W-1:0] POS_LIMIT = 64'd9999999999999;
   localparam logic [MAG_W-1:0] NEG_LIMIT = 64'd999999999999;

   localparam logic [SEG_W-1:0] MINUS_PATTERN = 7'h08;
   localparam logic [SEG_W-1:0] BLANK_PATTERN = 7'h00;

   // column addresses per row, most significant column first
   localparam logic [ADDR_W-1:0] ROW0_ADDR [PHYS_COLUMNS] = '{
      7'h50, 7'h52, 7'h54, 7'h56, 7'h58, 7'h5a, 7'h5c,
      7'h5e, 7'h60, 7'h62, 7'h64, 7'h66, 7'h68
   };
   localparam logic [ADDR_W-1:0] ROW1_ADDR [PHYS_COLUMNS] = '{
      7'h44, 7'h46, 7'h48, 7'h4a, 7'h4c, 7'h4e, 7'h6c,
      7'h6e, 7'h70, 7'h72, 7'h74, 7'h76, 7'h78
   };

   // converted number handed from the converter to the emitter
   typedef struct packed {
      logic                         neg;
      logic                         row;
      logic [BCD_DIGITS-1:0][3:0]   digits;
   } conv_result_type;

   // segment pattern of one decimal digit
   function automatic logic [SEG_W-1:0] digit_shape(input logic [3:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0:    seg = 7'h77;
         4'd1:    seg = 7'h12;
         4'd2:    seg = 7'h6b;
         4'd3:    seg = 7'h5b;
         4'd4:    seg = 7'h1e;
         4'd5:    seg = 7'h5d;
         4'd6:    seg = 7'h7d;
         4'd7:    seg = 7'h13;
         4'd8:    seg = 7'h7f;
         4'd9:    seg = 7'h5f;
         default: seg = BLANK_PATTERN;
      endcase
      return seg;
   endfunction

   // ram address of a column, counted from the least significant one;
   // columns past the physical ones stick at the top column
   function automatic logic [ADDR_W-1:0] col_addr(input logic row, input logic [4:0] col);
      logic [3:0] c;
      logic [3:0] idx;
      c   = (col < 5'(PHYS_COLUMNS)) ? col[3:0] : 4'(PHYS_COLUMNS - 1);
      idx = 4'(PHYS_COLUMNS - 1) - c;
      return row ? ROW1_ADDR[idx] : ROW0_ADDR[idx];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sdsr_ifs.sv -----
// sdsr_ifs: valid/ready channel interfaces for request and response
// depends on sdsr_pkg for field widths
`default_nettype none

interface sdsr_req_if;
   logic                              valid;
   logic                              ready;
   logic                              row;
   logic signed [sdsr_pkg::MAG_W-1:0] value;
   logic                              allow_overflow;

   modport source (output valid, output row, output value, output allow_overflow,
                   input ready);
   modport sink   (input valid, input row, input value, input allow_overflow,
                   output ready);
endinterface

interface sdsr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sdsr_pkg::ADDR_W-1:0] ram_address;
   logic [sdsr_pkg::SEG_W-1:0]  segments;
   logic                        last;

   modport source (output valid, output ram_address, output segments, output last,
                   input ready);
   modport sink   (input valid, input ram_address, input segments, input last,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/signed_decimal_seven_segment_render_top.sv -----
// signed_decimal_seven_segment_render_top: renders a signed number as
// seven-segment column writes; depends on sdsr_pkg, sdsr_ifs, sdsr_converter,
// sdsr_emitter
//
//   channel   dir   handshake     payload
//   req_ch    in    valid/ready   row, value, allow_overflow
//   rsp_ch    out   valid/ready   ram_address, segments, last
//
// a number runs through the bcd cell chain (5 bits per cycle over 65 bits)
// and is then handed off to the emitter, then DIGIT_COUNT response
// transactions leave one per cycle while rsp_ch is ready
// conversion of the next number overlaps emission of the current one, so a
// new number can be taken while the emitter still sends the last one
// a stall on rsp_ch holds the emitter; the converter then holds its result
// and req_ch.ready stays low until the emitter loads it
// synchronous active-high reset clears all control state; no clearing pass
`default_nettype none

module signed_decimal_seven_segment_render_top #(
   parameter int DIGIT_COUNT = sdsr_pkg::DIGIT_COUNT_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sdsr_req_if.sink   req_ch,
   sdsr_rsp_if.source rsp_ch
);
   import sdsr_pkg::*;

   conv_result_type result;
   logic            result_valid;
   logic            result_ready;

   // binary to bcd front end
   sdsr_converter u_converter (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .result       (result),
      .result_valid (result_valid),
      .result_ready (result_ready)
   );

   // column writer
   sdsr_emitter #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_emitter (
      .clock        (clock),
      .reset        (reset),
      .result       (result),
      .result_valid (result_valid),
      .result_ready (result_ready),
      .rsp_ch       (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- hdl/sdsr_bcd_cell.sv -----
// sdsr_bcd_cell: one bcd digit of the double-dabble chain, several shift
// steps per clock; depends on sdsr_pkg
`default_nettype none

module sdsr_bcd_cell (
   input  wire logic                          clock,
   input  wire logic                          clear,
   input  wire logic                          enable,
   input  wire logic [sdsr_pkg::STEP_BITS-1:0] in_bits,
   output logic      [sdsr_pkg::STEP_BITS-1:0] out_bits,
   output logic      [3:0]                     digit
);
   import sdsr_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in;

   // add-3 correction then shift, once per sub-step; bit k enters at sub-step k
   always_comb begin
      logic [3:0] d;
      d        = digit_ff;
      out_bits = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
         if (d >= 4'd5) begin
            d = d + 4'd3;
         end
         out_bits[k] = d[3];
         d           = {d[2:0], in_bits[k]};
      end
      digit_in = d;
   end

   // digit register, cleared when a new number is loaded
   always_ff @(posedge clock) begin
      if (clear) begin
         digit_ff <= '0;
      end else if (enable) begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

// ----- hdl/sdsr_converter.sv -----
// sdsr_converter: takes a request transaction, clamps and folds the sign,
// then runs the bcd cell chain; depends on sdsr_pkg, sdsr_ifs, sdsr_bcd_cell
`default_nettype none

module sdsr_converter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   sdsr_req_if.sink                     req_ch,
   output sdsr_pkg::conv_result_type    result,
   output logic                         result_valid,
   input  wire logic                    result_ready
);
   import sdsr_pkg::*;

   logic                  busy_ff, busy_in;
   logic [STEP_CNT_W-1:0] count_ff, count_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic                  neg_ff, row_ff;

   logic                  accept;
   logic                  done;
   logic                  handoff;
   logic                  step_en;
   logic                  neg;
   logic [MAG_W-1:0]      mag;
   logic [MAG_W-1:0]      mag_clamped;

   logic [STEP_BITS-1:0]  chain [BCD_DIGITS+1];
   logic [3:0]            digits [BCD_DIGITS];

   // handshake
   assign done     = busy_ff && (count_ff == STEP_CNT_W'(CONV_STEPS));
   assign handoff  = done && result_ready;
   assign step_en  = busy_ff && !done;
   assign req_ch.ready = !busy_ff || handoff;
   assign accept   = req_ch.valid && req_ch.ready;

   // magnitude as unsigned, then clamp unless overflow is allowed
   always_comb begin
      neg = req_ch.value[MAG_W-1];
      mag = neg ? (~req_ch.value + 64'd1) : req_ch.value;
      mag_clamped = mag;
      if (!req_ch.allow_overflow) begin
         if (!neg && (mag > POS_LIMIT)) begin
            mag_clamped = POS_LIMIT;
         end
         if (neg && (mag > NEG_LIMIT)) begin
            mag_clamped = NEG_LIMIT;
         end
      end
   end

   // control next state
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (accept) begin
         busy_in  = 1'b1;
         count_in = '0;
      end else if (handoff) begin
         busy_in  = 1'b0;
      end else if (step_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   // binary shift register, msb first
   always_comb begin
      bin_in = bin_ff;
      if (accept) begin
         bin_in = {{(BIN_W - MAG_W){1'b0}}, mag_clamped};
      end else if (step_en) begin
         bin_in = bin_ff << STEP_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      if (accept) begin
         neg_ff <= neg;
         row_ff <= req_ch.row;
      end
   end

   // bits for this cycle's sub-steps feed the lowest digit
   always_comb begin
      for (int k = 0; k < STEP_BITS; k++) begin
         chain[0][k] = bin_ff[BIN_W-1-k];
      end
   end

   // row of digit cells, each passing its carried-out bits upward
   for (genvar i = 0; i < BCD_DIGITS; i++) begin : g_cell
      sdsr_bcd_cell u_cell (
         .clock    (clock),
         .clear    (accept),
         .enable   (step_en),
         .in_bits  (chain[i]),
         .out_bits (chain[i+1]),
         .digit    (digits[i])
      );
   end

   // converted number
   always_comb begin
      result.neg = neg_ff;
      result.row = row_ff;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         result.digits[i] = digits[i];
      end
   end

   assign result_valid = done;

endmodule

`default_nettype wire

// ----- hdl/sdsr_emitter.sv -----
// sdsr_emitter: shifts converted digits out as one response transaction per
// column; depends on sdsr_pkg and sdsr_ifs
`default_nettype none

module sdsr_emitter #(
   parameter int DIGIT_COUNT = sdsr_pkg::DIGIT_COUNT_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sdsr_pkg::conv_result_type result,
   input  wire logic                    result_valid,
   output logic                         result_ready,
   sdsr_rsp_if.source                   rsp_ch
);
   import sdsr_pkg::*;

   localparam int COL_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   logic             busy_ff, busy_in;
   logic [COL_W-1:0] col_ff;
   logic             neg_ff, row_ff, minus_done_ff;
   logic [3:0]       digit_ff [DIGIT_COUNT];
   logic             nz_ff    [DIGIT_COUNT];

   logic             fire;
   logic             last;
   logic             load;
   logic             nz_load  [DIGIT_COUNT];
   logic             show_minus;

   assign fire         = busy_ff && rsp_ch.ready;
   assign last         = (col_ff == COL_W'(DIGIT_COUNT - 1));
   assign result_ready = !busy_ff || (fire && last);
   assign load         = result_valid && result_ready;

   // remaining value nonzero at each column: any digit at or above it
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         nz_load[i] = 1'b0;
         for (int j = i; j < BCD_DIGITS; j++) begin
            nz_load[i] = nz_load[i] | (result.digits[j] != 4'd0);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (fire && last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // digit cells: load in parallel, shift toward column zero per transaction
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_ff[i] <= result.digits[i];
            nz_ff[i]    <= nz_load[i];
         end
      end else if (fire) begin
         for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
            digit_ff[i] <= digit_ff[i+1];
            nz_ff[i]    <= nz_ff[i+1];
         end
         digit_ff[DIGIT_COUNT-1] <= 4'd0;
         nz_ff[DIGIT_COUNT-1]    <= 1'b0;
      end
   end

   // column counter and sign tracking
   assign show_minus = !nz_ff[0] && neg_ff && !minus_done_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff        <= '0;
         neg_ff        <= result.neg;
         row_ff        <= result.row;
         minus_done_ff <= 1'b0;
      end else if (fire) begin
         col_ff <= col_ff + 1'b1;
         if (show_minus) begin
            minus_done_ff <= 1'b1;
         end
      end
   end

   // response payload
   always_comb begin
      rsp_ch.valid       = busy_ff;
      rsp_ch.ram_address = col_addr(row_ff, 5'(col_ff));
      rsp_ch.last        = last;
      if (nz_ff[0]) begin
         rsp_ch.segments = digit_shape(digit_ff[0]);
      end else if (show_minus) begin
         rsp_ch.segments = MINUS_PATTERN;
      end else begin
         rsp_ch.segments = BLANK_PATTERN;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/sdsr_checker.sv -----
// sdsr_checker: port-level assertions for the renderer top, attached by bind
// depends on sdsr_pkg for widths
`default_nettype none

module sdsr_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [sdsr_pkg::ADDR_W-1:0] rsp_ram_address,
   input wire logic [sdsr_pkg::SEG_W-1:0]  rsp_segments,
   input wire logic                        rsp_last
);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_ram_address) && $stable(rsp_segments)
          && $stable(rsp_last)))
      else $error("stalled response changed");

   // columns of one number follow without gaps
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("gap inside a column burst");

   // a taken request makes the converter busy, so ready is low in the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while converting");

endmodule

bind signed_decimal_seven_segment_render_top sdsr_checker u_sdsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_ram_address (rsp_ch.ram_address),
   .rsp_segments    (rsp_ch.segments),
   .rsp_last        (rsp_ch.last)
);

`default_nettype wire

// ----- tb/tb_signed_decimal_seven_segment_render_top.sv -----
// tb_signed_decimal_seven_segment_render_top: self-checking bench for the signed decimal
// seven-segment renderer; predicts the 13 column writes of every number and checks them in order
// depends on sdsr_pkg, sdsr_ifs and signed_decimal_seven_segment_render_top
`timescale 1ns / 100ps
`default_nettype none

module tb_signed_decimal_seven_segment_render_top;

   localparam int NUM_COLUMNS = 13;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   // clamp limits and patterns of the display
   localparam logic [63:0] POS_CLAMP = 64'd9999999999999;
   localparam logic [63:0] NEG_CLAMP = 64'd999999999999;
   localparam logic [sdsr_pkg::SEG_W-1:0] SEG_MINUS = 7'h08;
   localparam logic [sdsr_pkg::SEG_W-1:0] SEG_BLANK = 7'h00;

   localparam logic [sdsr_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
      7'h77, 7'h12, 7'h6b, 7'h5b, 7'h1e, 7'h5d, 7'h7d, 7'h13, 7'h7f, 7'h5f
   };

   // column addresses, least significant column first
   localparam logic [sdsr_pkg::ADDR_W-1:0] ROW0_COLS [NUM_COLUMNS] = '{
      7'h68, 7'h66, 7'h64, 7'h62, 7'h60, 7'h5e, 7'h5c,
      7'h5a, 7'h58, 7'h56, 7'h54, 7'h52, 7'h50
   };
   localparam logic [sdsr_pkg::ADDR_W-1:0] ROW1_COLS [NUM_COLUMNS] = '{
      7'h78, 7'h76, 7'h74, 7'h72, 7'h70, 7'h6e, 7'h6c,
      7'h4e, 7'h4c, 7'h4a, 7'h48, 7'h46, 7'h44
   };

   typedef struct packed {
      logic [sdsr_pkg::ADDR_W-1:0] addr;
      logic [sdsr_pkg::SEG_W-1:0]  seg;
      logic                        last;
   } column_write_type;

   logic clock;
   logic reset;

   sdsr_req_if req_if ();
   sdsr_rsp_if rsp_if ();

   signed_decimal_seven_segment_render_top #(
      .DIGIT_COUNT(NUM_COLUMNS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   column_write_type expected_writes [$];
   int unsigned   values_sent;
   int unsigned   writes_checked;
   int unsigned   fail_count;
   int unsigned   cycle_count;
   int unsigned   long_hold_req;
   int unsigned   long_holds_done;
   bit            src_idle_en;
   bit            sink_idle_en;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d writes still expected",
                  cycle_count, expected_writes.size());
         $display("signed_decimal_seven_segment_render_top verification failed");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   // expected column writes of one number
   function automatic void predict_render(input logic row, input logic signed [63:0] value,
                                          input logic allow);
      logic [63:0]      raw;
      logic [63:0]      mag;
      logic             neg;
      bit               sign_shown;
      column_write_type w;
      raw = value;
      neg = raw[63];
      mag = neg ? (~raw + 64'd1) : raw;
      if (!allow) begin
         if (!neg && mag > POS_CLAMP)
            mag = POS_CLAMP;
         if (neg && mag > NEG_CLAMP)
            mag = NEG_CLAMP;
      end
      sign_shown = 1'b0;
      for (int col = 0; col < NUM_COLUMNS; col++) begin
         if (mag != 64'd0) begin
            w.seg = DIGIT_SEGS[int'(mag % 64'd10)];
         end else if (neg && !sign_shown) begin
            w.seg = SEG_MINUS;
            sign_shown = 1'b1;
         end else begin
            w.seg = SEG_BLANK;
         end
         mag = mag / 64'd10;
         w.addr = row ? ROW1_COLS[col] : ROW0_COLS[col];
         w.last = (col == NUM_COLUMNS - 1);
         expected_writes.push_back(w);
      end
   endfunction

   // check every accepted column write against the oldest expectation
   always @(posedge clock) begin : check_writes
      column_write_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_writes.size() == 0) begin
            note_failure($sformatf("unexpected write addr=%h seg=%h last=%b",
                                   rsp_if.ram_address, rsp_if.segments, rsp_if.last));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_if.ram_address !== want.addr || rsp_if.segments !== want.seg ||
                rsp_if.last !== want.last)
               note_failure($sformatf(
                  "write %0d: expected addr=%h seg=%h last=%b, got addr=%h seg=%h last=%b",
                  writes_checked, want.addr, want.seg, want.last,
                  rsp_if.ram_address, rsp_if.segments, rsp_if.last));
         end
         writes_checked++;
      end
   end

   // response ready: random stall bursts, plus long holds on request
   initial begin : drive_rsp_ready
      int unsigned stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req != 0) begin
            stall_left = long_hold_req;
            long_hold_req = 0;
            long_holds_done++;
         end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
         end
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // offer one number and wait for its transaction; valid stays high afterwards
   task automatic send_value(input logic row, input logic signed [63:0] value, input logic allow);
      int unsigned gap;
      @(negedge clock);
      if (src_idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.row            <= row;
      req_if.value          <= value;
      req_if.allow_overflow <= allow;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_render(row, value, allow);
      values_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_writes.size() != 0)
         @(posedge clock);
   endtask

   // mix of short decimals, clamp edges, 64-bit extremes and raw random bits
   function automatic logic signed [63:0] rand_value();
      logic [63:0] bits;
      logic [63:0] span;
      int unsigned digits;
      bits = {$urandom, $urandom};
      case ($urandom_range(0, 9)) inside
         [0:3]: begin
            digits = $urandom_range(1, 18);
            span = 64'd1;
            repeat (digits) span = span * 64'd10;
            bits = bits % span;
            if ($urandom_range(0, 1))
               bits = ~bits + 64'd1;
         end
         4: bits = POS_CLAMP + 64'($urandom_range(0, 4)) - 64'd2;
         5: bits = ~(NEG_CLAMP + 64'($urandom_range(0, 4)) - 64'd2) + 64'd1;
         6: begin
            if ($urandom_range(0, 1))
               bits = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            else
               bits = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 3));
         end
         default: ;
      endcase
      return bits;
   endfunction

   // field extremes, clamps, sign placement and digit coverage
   task automatic test_directed_edges();
      send_value(1'b0, 64'sd0, 1'b0);
      send_value(1'b1, 64'sd0, 1'b1);
      send_value(1'b0, 64'sd1, 1'b0);
      send_value(1'b1, -64'sd1, 1'b0);
      send_value(1'b0, -64'sd9, 1'b1);
      send_value(1'b1, 64'sd10, 1'b0);
      send_value(1'b0, 64'sd9876543210, 1'b0);
      send_value(1'b1, 64'sd1023456789, 1'b0);
      send_value(1'b0, 64'sd9999999999999, 1'b0);
      send_value(1'b1, 64'sd10000000000000, 1'b0);
      send_value(1'b0, -64'sd999999999999, 1'b0);
      send_value(1'b1, -64'sd1000000000000, 1'b0);
      send_value(1'b0, 64'sh7fff_ffff_ffff_ffff, 1'b0);
      send_value(1'b1, 64'sh7fff_ffff_ffff_ffff, 1'b1);
      send_value(1'b0, 64'sh8000_0000_0000_0000, 1'b0);
      send_value(1'b1, 64'sh8000_0000_0000_0000, 1'b1);
      // negative with all thirteen columns used: no room for the sign
      send_value(1'b0, -64'sd1234567890123, 1'b1);
      send_value(1'b1, -64'sd123456789012, 1'b1);
      send_value(1'b0, -64'sd12345678901234, 1'b1);
      send_value(1'b1, 64'sd12345678901234, 1'b1);
      send_value(1'b0, 64'shffff_ffff_ffff_ffff, 1'b1);
      send_value(1'b1, 64'sh5555_aaaa_5555_aaaa, 1'b1);
      drop_valid();
   endtask

   task automatic test_random_mixed(input int unsigned count);
      repeat (count)
         send_value(1'($urandom_range(0, 1)), rand_value(), 1'($urandom_range(0, 1)));
      drop_valid();
   endtask

   // long receiver hold while numbers keep coming, so the input stalls
   task automatic test_backpressure();
      bit idle_save;
      idle_save = src_idle_en;
      src_idle_en = 1'b0;
      long_hold_req = 200;
      repeat (8)
         send_value(1'($urandom_range(0, 1)), rand_value(), 1'($urandom_range(0, 1)));
      drop_valid();
      src_idle_en = idle_save;
   endtask

   // closing stretch at full rate with no idling on either side
   task automatic test_streaming(input int unsigned count);
      src_idle_en = 1'b0;
      sink_idle_en = 1'b0;
      repeat (count)
         send_value(1'($urandom_range(0, 1)), rand_value(), 1'($urandom_range(0, 1)));
      drop_valid();
   endtask

   // reset, tests in turn, drain and verdict
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.row = 1'b0;
      req_if.value = '0;
      req_if.allow_overflow = 1'b0;
      src_idle_en = 1'b1;
      sink_idle_en = 1'b1;
      long_hold_req = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_random_mixed(130);
      test_backpressure();
      test_random_mixed(20);
      test_streaming(40);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_writes.size() != 0)
         note_failure($sformatf("%0d writes never arrived", expected_writes.size()));

      $display("run covered %0d numbers and %0d column writes, %0d long receiver hold(s)",
               values_sent, writes_checked, long_holds_done);
      $display("clamping, overflow, sign placement and both rows exercised, %0d failure(s)",
               fail_count);
      if (fail_count == 0) begin
         $display("signed_decimal_seven_segment_render_top verification clean");
      end else begin
         $display("signed_decimal_seven_segment_render_top verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- signed_decimal_seven_segment_render_top.f -----
hdl/sdsr_pkg.sv
hdl/sdsr_ifs.sv
hdl/sdsr_bcd_cell.sv
hdl/sdsr_converter.sv
hdl/sdsr_emitter.sv
hdl/signed_decimal_seven_segment_render_top.sv
hdl/sdsr_checker.sv
tb/tb_signed_decimal_seven_segment_render_top.sv
